>>> rtl/core/l2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2s_pkg
// Types, constants and single-precision helpers for the sRGB encoder.
// ----------------------------------------------------------------------------
package l2s_pkg;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_in;
  } l2s_in_t;

  typedef struct packed {
    logic [31:0] encoded_bits;
    logic        last_out;
  } l2s_out_t;

  localparam logic [31:0] MagMask   = 32'h7fff_ffff;
  localparam logic [31:0] RedOr     = 32'h3e80_0000;
  localparam logic [31:0] RedAnd    = 32'h3eff_ffff;
  localparam logic [7:0]  ExpBias   = 8'd118;
  localparam logic [31:0] ScaleBase = 32'h4000_0000;
  localparam logic [31:0] C3        = 32'h3d75_686e; // 0.059914046
  localparam logic [31:0] C2N       = 32'hbddf_041c; // -0.10889456
  localparam logic [31:0] C1        = 32'h3ddd_1c1a; // 0.107963754
  localparam logic [31:0] C0        = 32'h3c94_3665; // 0.018092343
  localparam logic [31:0] K1292     = 32'h414e_b852; // 12.92
  localparam logic [31:0] K055N     = 32'hbd61_47ae; // -0.055
  localparam logic [31:0] Thresh    = 32'h3b4d_2e1c; // 0.0031308
  localparam int unsigned Stages    = 8;

  function automatic logic [7:0] hi_tab(input logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd0: v = 8'h00;  4'd1: v = 8'h0a;  4'd2: v = 8'h19;  4'd3: v = 8'h26;
      4'd4: v = 8'h32;  4'd5: v = 8'h41;  4'd6: v = 8'h4d;  4'd7: v = 8'h5c;
      4'd8: v = 8'h68;  4'd9: v = 8'h75;  4'd10: v = 8'h83; 4'd11: v = 8'h8f;
      4'd12: v = 8'ha0; 4'd13: v = 8'haa; 4'd14: v = 8'hb9; default: v = 8'hc6;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] lo_tab(input logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd0: v = 8'h00;  4'd1: v = 8'hb7;  4'd2: v = 8'h04;  4'd3: v = 8'h0d;
      4'd4: v = 8'hcb;  4'd5: v = 8'he7;  4'd6: v = 8'h41;  4'd7: v = 8'h68;
      4'd8: v = 8'h51;  4'd9: v = 8'hd1;  4'd10: v = 8'heb; 4'd11: v = 8'hf2;
      4'd12: v = 8'h00; 4'd13: v = 8'hb7; 4'd14: v = 8'h04; default: v = 8'h0d;
    endcase
    return v;
  endfunction

  // Round-to-nearest-even packing. m carries 24 significand bits plus guard
  // bits in [26:0] (leading one at bit 26 for normal range), e biased exponent
  // of bit 26, sticky ORed into bit 0.
  function automatic logic [31:0] fp_pack(input logic s, input logic signed [10:0] e,
                                           input logic [26:0] m);
    logic [26:0] mm;
    logic signed [10:0] ee;
    logic [4:0] sh;
    logic [24:0] r;
    logic lsb, g, st;
    mm = m;
    ee = e;
    if (ee < 11'sd1) begin
      sh = (ee < -11'sd25) ? 5'd27 : 5'(11'sd1 - ee);
      mm = (m >> sh) | 27'({26'd0, |(m & ~(27'h7ffffff << sh))});
      ee = 11'sd0;
    end
    lsb = mm[3];
    g   = mm[2];
    st  = |mm[1:0];
    r   = {1'b0, mm[26:3]} + 25'(g & (st | lsb));
    if (r[24]) begin
      r  = r >> 1;
      ee = ee + 11'sd1;
    end else if (ee == 11'sd0 && r[23]) begin
      ee = 11'sd1;
    end
    if (ee >= 11'sd255) return {s, 8'hff, 23'd0};
    return {s, ee[7:0], r[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [23:0] ma, mb;
    logic [47:0] pr;
    logic signed [10:0] e;
    logic [26:0] m;
    logic [5:0] lz;
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    pr = ma * mb;
    if (pr == 48'd0) return {a[31] ^ b[31], 31'd0};
    lz = 6'd0;
    for (int i = 47; i >= 0; i--) begin
      if (pr[i]) begin
        lz = 6'(47 - i);
        break;
      end
    end
    pr = pr << lz;
    e = 11'(a[30:23]) + 11'(!(|a[30:23])) + 11'(b[30:23]) + 11'(!(|b[30:23]))
        - 11'sd126 - 11'(lz);
    m = {pr[47:22], |pr[21:0]};
    return fp_pack(a[31] ^ b[31], e, m);
  endfunction

  // Adder for finite operands as met in this datapath.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [7:0] d;
    logic [27:0] mx, my, sm;
    logic signed [10:0] e;
    logic [4:0] lz;
    logic [26:0] m;
    if (a[30:0] >= b[30:0]) begin
      x = a; y = b;
    end else begin
      x = b; y = a;
    end
    mx = {1'b0, |x[30:23], x[22:0], 3'd0};
    my = {1'b0, |y[30:23], y[22:0], 3'd0};
    d  = x[30:23] + 8'(!(|x[30:23])) - y[30:23] - 8'(!(|y[30:23]));
    if (d > 8'd27) my = 28'(|my);
    else my = (my >> d) | 28'(|(my & ~(28'hfffffff << d)));
    sm = (x[31] == y[31]) ? mx + my : mx - my;
    if (sm == 28'd0) return 32'd0;
    e = 11'(x[30:23]) + 11'(!(|x[30:23])) + 11'sd1;
    lz = 5'd0;
    for (int i = 27; i >= 0; i--) begin
      if (sm[i]) begin
        lz = 5'(27 - i);
        break;
      end
    end
    sm = sm << lz;
    e = e - 11'(lz);
    m = {sm[27:2], |sm[1:0]};
    return fp_pack(x[31], e, m);
  endfunction

endpackage

>>> rtl/core/linear_to_srgb_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_to_srgb_encode
// Linear-light float32 to sRGB-encoded float32, one sample per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_ready_o carry an l2s_in_t request, out_valid_o/out_ready_i
//   an l2s_out_t result. A request is taken on valid && ready.
//   A result becomes valid after its request has passed eight register
//   stages of float work (three multiply-add steps of Horner, scale
//   multiply, final subtract and select).
//   Throughput is one sample per clock while the receiver does not stall; requests may follow back to back.
//   last_in travels with its sample as last_out.
//   Reset clears all stage valid bits; payload registers are not reset.
//   When the receiver stalls, the whole pipe holds; in_ready_o follows
//   the final stage being free or drained, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module linear_to_srgb_encode import l2s_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  l2s_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output l2s_out_t out_data_o
);

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] r;
    logic [31:0] lin;
    logic [31:0] scale;
    logic        use_lin;
    logic        neg;
    logic        last;
  } stg_t;

  logic [Stages-1:0] vld_q;
  stg_t              stg_q [Stages];
  stg_t              stg_d [Stages];
  logic              adv;

  assign adv        = !vld_q[Stages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    logic [31:0] mag, lo, hi, r;
    logic [3:0] k;
    mag = in_data_i.sample_bits & MagMask;
    r   = (mag | RedOr) & RedAnd;
    k   = 4'(mag[30:23] - ExpBias);
    stg_d[0].acc     = fp_mul(C3, r);
    stg_d[0].r       = r;
    stg_d[0].lin     = fp_mul(mag, K1292);
    stg_d[0].scale   = ScaleBase | (32'(hi_tab(k)) << 18) | (32'(lo_tab(k)) << 10);
    stg_d[0].use_lin = !(mag > Thresh);
    stg_d[0].neg     = in_data_i.sample_bits[31] && (mag != 32'd0) &&
                       !(mag[30:23] == 8'hff && mag[22:0] != 23'd0);
    stg_d[0].last    = in_data_i.last_in;
    lo = 32'd0;
    hi = 32'd0;
    for (int s = 1; s < Stages; s++) begin
      stg_d[s] = stg_q[s-1];
      case (s)
        1: stg_d[s].acc = fp_add(stg_q[s-1].acc, C2N);
        2: stg_d[s].acc = fp_mul(stg_q[s-1].acc, stg_q[s-1].r);
        3: stg_d[s].acc = fp_add(stg_q[s-1].acc, C1);
        4: stg_d[s].acc = fp_mul(stg_q[s-1].acc, stg_q[s-1].r);
        5: stg_d[s].acc = fp_add(stg_q[s-1].acc, C0);
        6: stg_d[s].acc = fp_mul(stg_q[s-1].acc, stg_q[s-1].scale);
        default: begin
          lo = fp_add(stg_q[s-1].acc, K055N);
          hi = stg_q[s-1].use_lin ? stg_q[s-1].lin : lo;
          stg_d[s].acc = {hi[31] ^ stg_q[s-1].neg, hi[30:0]};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < Stages; s++) stg_q[s] <= stg_d[s];
    end
  end

  assign out_valid_o             = vld_q[Stages-1];
  assign out_data_o.encoded_bits = stg_q[Stages-1].acc;
  assign out_data_o.last_out     = stg_q[Stages-1].last;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipe blocked while empty at output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost");

endmodule
